// ===== rtl/modbus_rtu_request_framer_top_macros.svh =====
// Assertion macros shared by the request framer RTL.
`ifndef MODBUS_RTU_REQUEST_FRAMER_TOP_MACROS_SVH
`define MODBUS_RTU_REQUEST_FRAMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define MRF_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("mrf: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define MRF_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("mrf: next-cycle check failed");

`endif

// ===== rtl/mrf_pkg.sv =====
// Types, constants and helper functions of the Modbus RTU request framer.
package mrf_pkg;

  localparam int unsigned MAX_PAYLOAD_WORDS_DEF = 123;

  // Command codes of an input transaction.
  typedef enum logic [2:0] {
    CMD_READ_COILS   = 3'd0,
    CMD_READ_HOLDING = 3'd1,
    CMD_READ_INPUT   = 3'd2,
    CMD_WRITE_COIL   = 3'd3,
    CMD_WRITE_REG    = 3'd4,
    CMD_WRITE_MULTI  = 3'd5,
    CMD_PAYLOAD      = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ILLEGAL  = 2'd1,
    ST_BUSY     = 2'd2,
    ST_NO_FRAME = 2'd3
  } status_e;

  localparam logic [7:0]  MAX_SLAVE_ADDR = 8'd254;
  localparam logic [15:0] COIL_ON        = 16'hFF00;
  localparam logic [15:0] COIL_OFF       = 16'h0000;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // Up to seven CRC-covered bytes per transaction, plus two CRC bytes.
  localparam int unsigned DATA_BYTES  = 7;
  localparam int unsigned DATA_IDX_W  = $clog2(DATA_BYTES);
  localparam int unsigned DATA_CNT_W  = $clog2(DATA_BYTES + 1);
  localparam int unsigned BYTE_IDX_W  = $clog2(DATA_BYTES + 2);

  // Queue between classifier and emitter; depth must be a power of two.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One classified transaction: the bytes to send and how to finish.
  typedef struct packed {
    logic [DATA_BYTES-1:0][7:0] data_bytes;
    logic [DATA_CNT_W-1:0]      n_data;
    logic                       tail;
    logic                       crc_init;
    status_e                    status;
  } entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] func_code(input cmd_e cmd);
    logic [7:0] f;
    unique case (cmd)
      CMD_READ_COILS:   f = 8'h01;
      CMD_READ_HOLDING: f = 8'h03;
      CMD_READ_INPUT:   f = 8'h04;
      CMD_WRITE_COIL:   f = 8'h05;
      CMD_WRITE_REG:    f = 8'h06;
      CMD_WRITE_MULTI:  f = 8'h10;
      default:          f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/mrf_front.sv =====
// Front end: accept a transaction, check it and track the open write-multiple frame.
module mrf_front #(
  parameter int unsigned MaxPayloadWords = mrf_pkg::MAX_PAYLOAD_WORDS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [2:0]      command_i,
  input  logic [7:0]      slave_address_i,
  input  logic [15:0]     start_address_i,
  input  logic [15:0]     count_or_value_i,
  input  logic [15:0]     data_word_i,
  input  logic            link_busy_i,
  input  logic            q_full_i,
  output logic            push_o,
  output mrf_pkg::entry_t entry_o
);

  localparam int unsigned CntW = $clog2(MaxPayloadWords + 1);

  logic            open_q, open_d;
  logic [CntW-1:0] words_q, words_d;
  logic            refuse;
  mrf_pkg::status_e rstat;
  mrf_pkg::entry_t  ent;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign entry_o    = ent;

  always_comb begin
    ent          = '0;
    ent.status   = mrf_pkg::ST_OK;
    open_d       = open_q;
    words_d      = words_q;
    refuse       = 1'b0;
    rstat        = mrf_pkg::ST_OK;
    if (command_i == mrf_pkg::CMD_PAYLOAD) begin
      if (!open_q) begin
        refuse = 1'b1;
        rstat  = mrf_pkg::ST_NO_FRAME;
      end else begin
        ent.data_bytes[0] = data_word_i[15:8];
        ent.data_bytes[1] = data_word_i[7:0];
        ent.n_data        = mrf_pkg::DATA_CNT_W'(2);
        words_d           = words_q - CntW'(1);
        if (words_q == CntW'(1)) begin
          ent.tail = 1'b1;
          open_d   = 1'b0;
        end
      end
    end else if (command_i > mrf_pkg::CMD_PAYLOAD) begin
      refuse = 1'b1;
      rstat  = mrf_pkg::ST_ILLEGAL;
    end else if (slave_address_i > mrf_pkg::MAX_SLAVE_ADDR) begin
      refuse = 1'b1;
      rstat  = mrf_pkg::ST_ILLEGAL;
    end else if (link_busy_i || open_q) begin
      refuse = 1'b1;
      rstat  = mrf_pkg::ST_BUSY;
    end else if (command_i == mrf_pkg::CMD_WRITE_COIL &&
                 count_or_value_i != mrf_pkg::COIL_ON &&
                 count_or_value_i != mrf_pkg::COIL_OFF) begin
      refuse = 1'b1;
      rstat  = mrf_pkg::ST_ILLEGAL;
    end else if (command_i == mrf_pkg::CMD_WRITE_MULTI &&
                 count_or_value_i > 16'(MaxPayloadWords)) begin
      refuse = 1'b1;
      rstat  = mrf_pkg::ST_ILLEGAL;
    end else begin
      ent.crc_init      = 1'b1;
      ent.data_bytes[0] = slave_address_i;
      ent.data_bytes[1] = mrf_pkg::func_code(mrf_pkg::cmd_e'(command_i));
      ent.data_bytes[2] = start_address_i[15:8];
      ent.data_bytes[3] = start_address_i[7:0];
      ent.data_bytes[4] = count_or_value_i[15:8];
      ent.data_bytes[5] = count_or_value_i[7:0];
      if (command_i == mrf_pkg::CMD_WRITE_MULTI) begin
        // byte count is twice the word count, kept to eight bits
        ent.data_bytes[6] = {count_or_value_i[6:0], 1'b0};
        ent.n_data        = mrf_pkg::DATA_CNT_W'(7);
        if (count_or_value_i != 16'h0000) begin
          open_d  = 1'b1;
          words_d = count_or_value_i[CntW-1:0];
        end else begin
          ent.tail = 1'b1;
        end
      end else begin
        ent.n_data = mrf_pkg::DATA_CNT_W'(6);
        ent.tail   = 1'b1;
      end
    end
    if (refuse) begin
      ent        = '0;
      ent.n_data = mrf_pkg::DATA_CNT_W'(1);
      ent.status = rstat;
      open_d     = open_q;
      words_d    = words_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      words_q <= '0;
    end else if (push_o) begin
      open_q  <= open_d;
      words_q <= words_d;
    end
  end

endmodule

// ===== rtl/mrf_queue.sv =====
// Short queue of classified transactions between front and back.
module mrf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mrf_pkg::entry_t entry_i,
  input  logic            pop_i,
  output mrf_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  mrf_pkg::entry_t                  slots_q [mrf_pkg::Q_DEPTH];
  logic [mrf_pkg::Q_PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [mrf_pkg::Q_CNT_W-1:0]      count_q;

  assign head_o  = slots_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == mrf_pkg::Q_CNT_W'(mrf_pkg::Q_DEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + mrf_pkg::Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + mrf_pkg::Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + mrf_pkg::Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - mrf_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/mrf_back.sv =====
// Back end: emit the bytes of the head transaction, run the CRC, drive the output register.
module mrf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mrf_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            mid_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      frame_byte_o,
  output logic            last_byte_o,
  output logic [1:0]      status_o
);

  logic [mrf_pkg::BYTE_IDX_W-1:0] idx_q, total;
  logic [15:0] crc_q, crc_d, crc_base;
  logic        adv, is_last, in_data, tail_lo;
  logic [7:0]  cur_byte;
  logic        out_valid_q, last_q;
  logic [7:0]  byte_q;
  logic [1:0]  status_q;

  assign total   = mrf_pkg::BYTE_IDX_W'(head_i.n_data) +
                   (head_i.tail ? mrf_pkg::BYTE_IDX_W'(2) : '0);
  assign adv     = !empty_i && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == total - mrf_pkg::BYTE_IDX_W'(1));
  assign in_data = (idx_q < mrf_pkg::BYTE_IDX_W'(head_i.n_data));
  assign tail_lo = (idx_q == mrf_pkg::BYTE_IDX_W'(head_i.n_data));
  assign pop_o   = adv && is_last;
  assign mid_o   = (idx_q != '0);

  always_comb begin
    if (in_data) begin
      cur_byte = head_i.data_bytes[idx_q[mrf_pkg::DATA_IDX_W-1:0]];
    end else if (tail_lo) begin
      cur_byte = crc_q[7:0];
    end else begin
      cur_byte = crc_q[15:8];
    end
  end

  // Restart the CRC on the first byte of a request.
  assign crc_base = (head_i.crc_init && idx_q == '0) ? mrf_pkg::CRC_INIT : crc_q;

  always_comb begin
    crc_d = crc_q;
    if (in_data && head_i.status == mrf_pkg::ST_OK) begin
      crc_d = mrf_pkg::crc_byte(crc_base, cur_byte);
    end else if (!in_data && !tail_lo) begin
      crc_d = mrf_pkg::CRC_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      crc_q       <= mrf_pkg::CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        idx_q       <= is_last ? '0 : idx_q + mrf_pkg::BYTE_IDX_W'(1);
        crc_q       <= crc_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q   <= cur_byte;
      last_q   <= is_last;
      status_q <= head_i.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = last_q;
  assign status_o     = status_q;

endmodule

// ===== rtl/modbus_rtu_request_framer_top.sv =====
// Top level of the Modbus RTU request framer: front, queue and back wired together.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------------
//  in      | in_valid_i / in_stall_o | command_i slave_address_i start_address_i
//          |                         | count_or_value_i data_word_i link_busy_i
//  out     | out_valid_o/out_stall_i | frame_byte_o last_byte_o status_o
//
// Output: one result byte per cycle out of the back end's single byte register while
//   out_stall_i is low and the queue is not empty; a request is 8 bytes (9 for
//   write multiple with count zero, 7 when it opens a frame), a payload word 2 (4 on
//   the closing word), a refusal 1, each sent via the queue and the output register.
// Reset: clears the frame state, queue pointers and CRC at once; no clearing pass.
// Stalls: in_stall_o rises only when the two-entry queue is full; out_stall_i holds the
//   output register while the back end keeps the queue head.
`include "modbus_rtu_request_framer_top_macros.svh"

module modbus_rtu_request_framer_top #(
  parameter int unsigned MaxPayloadWords = mrf_pkg::MAX_PAYLOAD_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  slave_address_i,
  input  logic [15:0] start_address_i,
  input  logic [15:0] count_or_value_i,
  input  logic [15:0] data_word_i,
  input  logic        link_busy_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o,
  output logic [1:0]  status_o
);

  mrf_pkg::entry_t push_entry, head_entry;
  logic            push, pop, q_empty, q_full, back_mid;

  // Classify each transaction and keep the write-multiple frame state.
  mrf_front #(
    .MaxPayloadWords(MaxPayloadWords)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .slave_address_i  (slave_address_i),
    .start_address_i  (start_address_i),
    .count_or_value_i (count_or_value_i),
    .data_word_i      (data_word_i),
    .link_busy_i      (link_busy_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  // Decouple classification from byte emission.
  mrf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Walk the head transaction byte by byte, append the CRC where asked.
  mrf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_entry),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .mid_o        (back_mid),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o),
    .status_o     (status_o)
  );

  // The back end is never part way through a transaction the queue no longer holds.
  `MRF_ASSERT_IMP(a_mid_has_head, back_mid, !q_empty)
  // A refusal is a single zero byte carrying the last mark.
  `MRF_ASSERT_IMP(a_refusal_shape,
                  out_valid_o && status_o != mrf_pkg::ST_OK,
                  last_byte_o && frame_byte_o == 8'h00)
  // An accepted transaction lands in the queue.
  `MRF_ASSERT_NXT(a_accept_queued, in_valid_i && !in_stall_o, !q_empty)

endmodule
